@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property, checked outside reset.
`define NHFL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define NHFL_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `NHFL_ASSERT(lbl, clk, rstn, !(cond), msg)

`else

`define NHFL_ASSERT(lbl, clk, rstn, prop, msg)
`define NHFL_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ design/nhfl_pkg.sv @@
`default_nettype none

package nhfl_pkg;

  localparam int NUM_PLANES       = 12;
  localparam int KINDS            = 6;
  localparam int PLANE_W          = 64;
  localparam int SQ_W             = 6;
  localparam int PIDX_W           = 4;
  localparam int FEAT_W           = 15;
  localparam int CAP_W            = 6;
  localparam int TOTAL_W          = 10;
  localparam int PCNT_W           = 7;
  localparam int BUCKET_W         = 5;
  localparam int ROW_W            = 9;
  localparam int NUM_TPLANES      = 11;
  localparam int KING_TPLANE      = 10;
  localparam int OPP_OFFSET       = 5;
  localparam int QUEUE_DEPTH      = 2;
  localparam int MAX_FEATURES_DEF = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET  = 6'd32;
  localparam logic [2:0]         KIND_PAWN  = 3'd0;
  localparam logic [2:0]         KIND_KING  = 3'd5;
  localparam logic [PLANE_W-1:0] RANK_EDGES = 64'hFF00_0000_0000_00FF;
  localparam logic [ROW_W-1:0]   TPLANES_PER_BUCKET = 9'd11;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_CAPACITY = 2'd2
  } nhfl_status_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_CHECK,
    BS_LOAD,
    BS_EMIT
  } nhfl_bstate_t;

  typedef struct packed {
    logic               side;
    logic [2:0]         piece_kind;
    logic [PLANE_W-1:0] piece_bits;
    logic               view_side;
    logic               board_done;
  } nhfl_in_t;

  typedef struct packed {
    logic [FEAT_W-1:0] feature_index;
    nhfl_status_t      status;
    logic              list_end;
  } nhfl_out_t;

  typedef struct packed {
    logic [NUM_PLANES-1:0][PLANE_W-1:0] planes;
    logic                               view;
  } nhfl_pos_t;

  function automatic logic [PCNT_W-1:0] popcount64(input logic [PLANE_W-1:0] b);
    logic [PCNT_W-1:0] c;
    c = '0;
    for (int s = 0; s < PLANE_W; s++) begin
      c = c + PCNT_W'(b[s]);
    end
    return c;
  endfunction

  function automatic logic [SQ_W-1:0] enc64(input logic [PLANE_W-1:0] b);
    logic [SQ_W-1:0] r;
    r = '0;
    for (int s = 0; s < PLANE_W; s++) begin
      if (b[s]) begin
        r = r | SQ_W'(s);
      end
    end
    return r;
  endfunction

  function automatic logic [PLANE_W-1:0] xform(input logic [PLANE_W-1:0] b,
                                               input logic [SQ_W-1:0] xm);
    logic [PLANE_W-1:0] r;
    r = '0;
    for (int s = 0; s < PLANE_W; s++) begin
      r[s] = b[SQ_W'(s) ^ xm];
    end
    return r;
  endfunction

  function automatic logic [PIDX_W-1:0] plane_src(input logic view,
                                                  input logic [PIDX_W-1:0] p);
    logic [PIDX_W-1:0] r;
    if (p < PIDX_W'(OPP_OFFSET)) begin
      r = (view ? PIDX_W'(KINDS) : '0) + p;
    end else if (p < PIDX_W'(KING_TPLANE)) begin
      r = (view ? '0 : PIDX_W'(KINDS)) + (p - PIDX_W'(OPP_OFFSET));
    end else begin
      r = PIDX_W'(KIND_KING);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/nnue_halfka_feature_list_top.sv @@
`default_nettype none
// Channel   Ports                     Handshake
// input     start, busy, in_data      taken when start && !busy
// result    out_valid, out_data       one-cycle strobe, no back-pressure
// config    cfg_we, cfg_data          written when cfg_we
//
// busy is high only while the two-entry position queue is full.
// The back end checks a position by picking up the queue head, scanning the 12 planes and deciding;
// it then loads each feature plane in turn, the king plane last, and emits its features one by one,
// or gives a single status result for an invalid or over-capacity position. Each result is registered.
// Reset (rst_n low, synchronous) clears the stored planes, the queue and sets the capacity to 32.
// Results are strobed once; the receiver cannot stall them.

module nnue_halfka_feature_list_top import nhfl_pkg::*; #(
  parameter int MaxFeatures = MAX_FEATURES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  nhfl_in_t         in_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output logic             out_valid,
  output nhfl_out_t        out_data
);

  logic             push, pop, q_empty, q_full;
  nhfl_pos_t        push_data, head;
  logic [CAP_W-1:0] capacity;

  nhfl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .capacity  (capacity)
  );

  nhfl_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  nhfl_back #(.MaxFeatures(MaxFeatures)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .capacity   (capacity),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ design/nhfl_front.sv @@
`default_nettype none

module nhfl_front import nhfl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  nhfl_in_t         in_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output nhfl_pos_t        push_data,
  output logic [CAP_W-1:0] capacity
);

  logic [NUM_PLANES-1:0][PLANE_W-1:0] planes_r, planes_nxt, planes_upd;
  logic [CAP_W-1:0]                   cap_r;
  logic [PIDX_W-1:0]                  widx;
  logic                               acc;

  assign busy     = q_full;
  assign acc      = start && !q_full;
  assign capacity = cap_r;

  always_comb begin
    planes_upd = planes_r;
    widx       = (in_data.side ? PIDX_W'(KINDS) : '0) + PIDX_W'(in_data.piece_kind);
    if (in_data.piece_kind < 3'(KINDS)) begin
      planes_upd[widx] = in_data.piece_bits;
    end
    push      = acc && in_data.board_done;
    push_data = '{planes: planes_upd, view: in_data.view_side};
    planes_nxt = planes_r;
    if (acc) begin
      planes_nxt = in_data.board_done ? '0 : planes_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= '0;
      cap_r    <= CAP_RESET;
    end else begin
      planes_r <= planes_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/nhfl_queue.sv @@
`default_nettype none
`include "assert_macros.svh"

module nhfl_queue import nhfl_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  nhfl_pos_t push_data,
  input  logic      pop,
  output nhfl_pos_t head,
  output logic      empty,
  output logic      full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  nhfl_pos_t         mem [Depth];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [CntW-1:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CntW'(Depth));
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PtrW'(Depth - 1)) ? '0 : wp_r + PtrW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PtrW'(Depth - 1)) ? '0 : rp_r + PtrW'(1);
      end
      cnt_r <= cnt_r + CntW'(push) - CntW'(pop);
    end
  end

  `NHFL_ASSERT_NEVER(a_push_full, clk, rst_n, push && full, "push into full queue")
  `NHFL_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty, "pop from empty queue")

endmodule

`default_nettype wire

@@ design/nhfl_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module nhfl_back import nhfl_pkg::*; #(
  parameter int MaxFeatures = MAX_FEATURES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  nhfl_pos_t        head,
  input  logic             head_valid,
  input  logic [CAP_W-1:0] capacity,
  output logic             pop,
  output logic             out_valid,
  output nhfl_out_t        out_data
);

  localparam int NW = $clog2(MaxFeatures + 1);

  nhfl_bstate_t       state_r, state_nxt;
  logic [PIDX_W-1:0]  idx_r, idx_nxt, rd_idx;
  logic [PLANE_W-1:0] occ_r, occ_nxt, work_r, work_nxt, rd_plane, low_bit;
  logic               bad_r, bad_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [SQ_W-1:0]    xm_r, xm_nxt, ksq, kt;
  logic [BUCKET_W-1:0] bucket_r, bucket_nxt;
  logic [PCNT_W-1:0]  pc;
  logic               board_bad, over_cap, last, emit_v;
  nhfl_out_t          emit_d, out_r;
  logic               out_valid_r;
  logic [ROW_W-1:0]   row;

  assign rd_plane  = head.planes[rd_idx];
  assign pc        = popcount64(rd_plane);
  assign board_bad = bad_r || (total_r > TOTAL_W'(MaxFeatures));
  assign over_cap  = total_r > TOTAL_W'(capacity);
  assign low_bit   = work_r & (~work_r + PLANE_W'(1));
  assign last      = (TOTAL_W'(n_r) + TOTAL_W'(1)) == total_r;
  assign row       = ROW_W'(bucket_r) * TPLANES_PER_BUCKET + ROW_W'(idx_r);
  assign ksq       = enc64(rd_plane);
  assign kt        = ksq ^ {head.view, head.view, head.view, 3'b000};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE:  if (head_valid) state_nxt = BS_SCAN;
      BS_SCAN:  if (idx_r == PIDX_W'(NUM_PLANES - 1)) state_nxt = BS_CHECK;
      BS_CHECK: state_nxt = (board_bad || over_cap) ? BS_IDLE : BS_LOAD;
      BS_LOAD:  state_nxt = BS_EMIT;
      BS_EMIT: begin
        if (work_r == '0) begin
          state_nxt = BS_LOAD;
        end else if (last) begin
          state_nxt = BS_IDLE;
        end
      end
      default:  state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    emit_v = 1'b0;
    emit_d = '{feature_index: '0, status: ST_OK, list_end: 1'b0};
    pop    = 1'b0;
    rd_idx = idx_r;
    unique case (state_r)
      BS_IDLE, BS_SCAN: begin
      end
      BS_CHECK: begin
        rd_idx = (head.view ? PIDX_W'(KINDS) : '0) + PIDX_W'(KIND_KING);
        if (board_bad) begin
          emit_v = 1'b1;
          emit_d = '{feature_index: '0, status: ST_INVALID, list_end: 1'b1};
          pop    = 1'b1;
        end else if (over_cap) begin
          emit_v = 1'b1;
          emit_d = '{feature_index: '0, status: ST_CAPACITY, list_end: 1'b1};
          pop    = 1'b1;
        end
      end
      BS_LOAD: rd_idx = plane_src(head.view, idx_r);
      BS_EMIT: begin
        if (work_r != '0) begin
          emit_v = 1'b1;
          emit_d = '{feature_index: {row, enc64(low_bit)}, status: ST_OK, list_end: last};
          pop    = last;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idx_nxt    = idx_r;
    occ_nxt    = occ_r;
    bad_nxt    = bad_r;
    total_nxt  = total_r;
    work_nxt   = work_r;
    n_nxt      = n_r;
    xm_nxt     = xm_r;
    bucket_nxt = bucket_r;
    case (state_r)
      BS_IDLE: begin
        idx_nxt   = '0;
        occ_nxt   = '0;
        bad_nxt   = 1'b0;
        total_nxt = '0;
      end
      BS_SCAN: begin
        idx_nxt   = idx_r + PIDX_W'(1);
        occ_nxt   = occ_r | rd_plane;
        total_nxt = total_r + TOTAL_W'(pc);
        if ((rd_plane & occ_r) != '0) bad_nxt = 1'b1;
        if ((idx_r == PIDX_W'(KIND_KING) || idx_r == PIDX_W'(KINDS) + PIDX_W'(KIND_KING))
            && pc != PCNT_W'(1)) bad_nxt = 1'b1;
        if ((idx_r == PIDX_W'(KIND_PAWN) || idx_r == PIDX_W'(KINDS) + PIDX_W'(KIND_PAWN))
            && (rd_plane & RANK_EDGES) != '0) bad_nxt = 1'b1;
      end
      BS_CHECK: begin
        idx_nxt    = '0;
        n_nxt      = '0;
        xm_nxt     = {head.view, head.view, head.view, ~kt[2], ~kt[2], ~kt[2]};
        bucket_nxt = {kt[5:3], kt[1:0] ^ {2{~kt[2]}}};
      end
      BS_LOAD: begin
        if (idx_r == PIDX_W'(KING_TPLANE)) begin
          work_nxt = xform(head.planes[KIND_KING] | head.planes[KINDS + KIND_KING], xm_r);
        end else begin
          work_nxt = xform(rd_plane, xm_r);
        end
      end
      BS_EMIT: begin
        if (work_r == '0) begin
          idx_nxt = idx_r + PIDX_W'(1);
        end else begin
          work_nxt = work_r & (work_r - PLANE_W'(1));
          n_nxt    = n_r + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit_v;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    occ_r    <= occ_nxt;
    bad_r    <= bad_nxt;
    total_r  <= total_nxt;
    work_r   <= work_nxt;
    n_r      <= n_nxt;
    xm_r     <= xm_nxt;
    bucket_r <= bucket_nxt;
    out_r    <= emit_d;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `NHFL_ASSERT(a_err_ends, clk, rst_n, out_valid_r && out_r.status != ST_OK |-> out_r.list_end, "error result without list end")
  `NHFL_ASSERT(a_work_has_pos, clk, rst_n, state_r != BS_IDLE |-> head_valid, "back busy with empty queue")

endmodule

`default_nettype wire

@@ tb/nnue_halfka_feature_list_top_test.sv @@
`timescale 1ns / 100ps

module nnue_halfka_feature_list_top_test;
  import nhfl_pkg::*;

  localparam logic [2:0] KIND_KNIGHT   = 3'd1;
  localparam logic [2:0] KIND_BISHOP   = 3'd2;
  localparam logic [2:0] KIND_ROOK     = 3'd3;
  localparam logic [2:0] KIND_QUEEN    = 3'd4;
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic       WHITE         = 1'b0;
  localparam logic       BLACK         = 1'b1;
  localparam int         NUM_PHASES    = 8;
  localparam int         QUIET_PHASE   = 5;
  localparam int         PHASE_ITEMS   = 40;
  localparam int         DRAIN_CYCLES  = 80;
  localparam int         STALL_LIMIT   = 3000;
  localparam int         MAX_PRINTS    = 40;

  typedef enum int {
    FLAW_OVERLAP,
    FLAW_NO_KING,
    FLAW_TWO_KINGS,
    FLAW_EDGE_PAWN,
    FLAW_CROWD,
    FLAW_NOISE
  } flaw_t;

  typedef struct {
    nhfl_in_t  item;
    bit        typed;
    nhfl_out_t want;
  } board_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  nhfl_in_t         in_data;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  logic             out_valid;
  nhfl_out_t        out_data;

  logic [PLANE_W-1:0] shadow_planes [NUM_PLANES];
  logic [CAP_W-1:0]   shadow_cap;
  nhfl_out_t          expected_feats [$];
  nhfl_out_t          fresh_feats [$];
  nhfl_in_t           position_items [$];
  board_row_t         board_rows [$];
  nhfl_out_t          want_feat;
  bit                 gaps_on;
  int                 err_count;
  int                 item_count;
  int                 stall_cycles;

  nnue_halfka_feature_list_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("%0t: MISMATCH %s", $realtime, msg);
    end
  endtask

  function automatic nhfl_out_t status_only(input nhfl_status_t st);
    nhfl_out_t r;
    r.feature_index = '0;
    r.status = st;
    r.list_end = 1'b1;
    return r;
  endfunction

  function automatic nhfl_in_t pack_item(input logic s, input logic [2:0] k,
                                         input logic [PLANE_W-1:0] b, input logic d);
    nhfl_in_t it;
    it.side = s;
    it.piece_kind = k;
    it.piece_bits = b;
    it.view_side = 1'($urandom_range(0, 1));
    it.board_done = d;
    return it;
  endfunction

  function automatic board_row_t mk_row(input logic s, input logic [2:0] k,
                                        input logic [PLANE_W-1:0] b, input logic v,
                                        input logic d, input bit typed);
    board_row_t r;
    r.item.side = s;
    r.item.piece_kind = k;
    r.item.piece_bits = b;
    r.item.view_side = v;
    r.item.board_done = d;
    r.typed = typed;
    r.want = status_only(ST_INVALID);
    return r;
  endfunction

  // Apply one load to the shadow board; on the last bitboard, produce the feature list.
  task automatic fold_bitboard(input nhfl_in_t it);
    logic [PLANE_W-1:0] occ;
    logic [PLANE_W-1:0] tp [NUM_TPLANES];
    bit                 good;
    int                 total, ksq, t, mir, canon, bucket, plane, ts, n, c, k;
    nhfl_out_t          r;
    fresh_feats.delete();
    if (it.piece_kind < KINDS) begin
      shadow_planes[it.side * KINDS + it.piece_kind] = it.piece_bits;
    end
    if (!it.board_done) begin
      return;
    end
    good = 1'b1;
    occ = '0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      if ((shadow_planes[i] & occ) != '0) good = 1'b0;
      occ |= shadow_planes[i];
    end
    if ($countones(shadow_planes[KIND_KING]) != 1 ||
        $countones(shadow_planes[KINDS + KIND_KING]) != 1) good = 1'b0;
    if (((shadow_planes[KIND_PAWN] | shadow_planes[KINDS + KIND_PAWN]) & RANK_EDGES) != '0) begin
      good = 1'b0;
    end
    total = $countones(occ);
    if (total > MAX_FEATURES_DEF) good = 1'b0;
    if (!good) begin
      fresh_feats.push_back(status_only(ST_INVALID));
    end else if (total > shadow_cap) begin
      fresh_feats.push_back(status_only(ST_CAPACITY));
    end else begin
      ksq = 0;
      for (int s = PLANE_W - 1; s >= 0; s--) begin
        if (shadow_planes[it.view_side * KINDS + KIND_KING][s]) ksq = s;
      end
      t = it.view_side ? (ksq ^ 56) : ksq;
      mir = ((t & 7) < 4) ? 7 : 0;
      canon = t ^ mir;
      bucket = (canon >> 3) * 4 + ((canon & 7) - 4);
      for (int p = 0; p < NUM_TPLANES; p++) tp[p] = '0;
      for (int i = 0; i < NUM_PLANES; i++) begin
        c = i / KINDS;
        k = i % KINDS;
        plane = (k == KIND_KING) ? KING_TPLANE : k + ((c == it.view_side) ? 0 : OPP_OFFSET);
        for (int sq = 0; sq < PLANE_W; sq++) begin
          if (shadow_planes[i][sq]) begin
            ts = (it.view_side ? (sq ^ 56) : sq) ^ mir;
            tp[plane][ts] = 1'b1;
          end
        end
      end
      n = 0;
      for (int p = 0; p < NUM_TPLANES; p++) begin
        for (int sq = 0; sq < PLANE_W; sq++) begin
          if (tp[p][sq]) begin
            r.feature_index = FEAT_W'((bucket * NUM_TPLANES + p) * PLANE_W + sq);
            r.status = ST_OK;
            r.list_end = (n + 1 == total);
            fresh_feats.push_back(r);
            n++;
          end
        end
      end
    end
    for (int i = 0; i < NUM_PLANES; i++) shadow_planes[i] = '0;
  endtask

  task automatic push_transaction(input nhfl_in_t it, input bit typed, input nhfl_out_t want);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    fold_bitboard(it);
    item_count++;
    if (typed) begin
      expected_feats.push_back(want);
    end else begin
      foreach (fresh_feats[i]) expected_feats.push_back(fresh_feats[i]);
    end
  endtask

  task automatic wait_drained(input int tail);
    @(negedge clk);
    start <= 1'b0;
    while (expected_feats.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_cap = v;
  endtask

  // Mostly legal positions with random content; about a third carry one flaw.
  task automatic build_position();
    logic [PLANE_W-1:0] pl [NUM_PLANES];
    logic [PLANE_W-1:0] occ;
    int                 npieces, sq, k, s, wk_sq, nload, tmp, j;
    int                 order [NUM_PLANES];
    flaw_t              flaw;
    nhfl_in_t           it;
    position_items.delete();
    occ = '0;
    wk_sq = 0;
    for (int i = 0; i < NUM_PLANES; i++) pl[i] = '0;
    npieces = ($urandom_range(0, 99) < 80) ? $urandom_range(2, 10) : $urandom_range(11, 32);
    for (int n = 0; n < npieces; n++) begin
      do sq = $urandom_range(0, 63); while (occ[sq]);
      if (n < 2) begin
        s = n;
        k = KIND_KING;
        if (n == 0) wk_sq = sq;
      end else begin
        s = $urandom_range(0, 1);
        k = $urandom_range(KIND_PAWN, KIND_QUEEN);
        if (k == KIND_PAWN && RANK_EDGES[sq]) k = $urandom_range(KIND_KNIGHT, KIND_QUEEN);
      end
      occ[sq] = 1'b1;
      pl[s * KINDS + k][sq] = 1'b1;
    end
    if ($urandom_range(0, 99) < 30) begin
      flaw = flaw_t'($urandom_range(FLAW_OVERLAP, FLAW_NOISE));
      case (flaw)
        FLAW_OVERLAP: begin
          pl[$urandom_range(KIND_PAWN, KIND_QUEEN)][wk_sq] = 1'b1;
        end
        FLAW_NO_KING: begin
          pl[$urandom_range(0, 1) * KINDS + KIND_KING] = '0;
        end
        FLAW_TWO_KINGS: begin
          pl[$urandom_range(0, 1) * KINDS + KIND_KING][$urandom_range(0, 63)] = 1'b1;
        end
        FLAW_EDGE_PAWN: begin
          pl[$urandom_range(0, 1) * KINDS + KIND_PAWN][$urandom_range(0, 1) * 56 +
                                                     $urandom_range(0, 7)] = 1'b1;
        end
        FLAW_CROWD: begin
          pl[KIND_ROOK] |= ~occ & ~(64'd1 << $urandom_range(0, 63));
        end
        default: begin
          for (int i = 0; i < NUM_PLANES; i++) begin
            pl[i] = {$urandom, $urandom} & {$urandom, $urandom};
          end
        end
      endcase
    end
    nload = 0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      if (pl[i] != '0 || $urandom_range(0, 1)) begin
        order[nload] = i;
        nload++;
      end
    end
    for (int i = nload - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < nload; i++) begin
      if ($urandom_range(0, 99) < 10) begin
        position_items.push_back(pack_item(1'(order[i] / KINDS), 3'(order[i] % KINDS),
                                           {$urandom, $urandom}, 1'b0));
      end
      if ($urandom_range(0, 99) < 8) begin
        position_items.push_back(pack_item(1'($urandom_range(0, 1)),
                                           3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                                           {$urandom, $urandom}, 1'b0));
      end
      position_items.push_back(pack_item(1'(order[i] / KINDS), 3'(order[i] % KINDS),
                                         pl[order[i]], 1'b0));
    end
    if (nload == 0 || $urandom_range(0, 99) < 12) begin
      position_items.push_back(pack_item(1'($urandom_range(0, 1)),
                                         3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                                         {$urandom, $urandom}, 1'b1));
    end else begin
      it = position_items.pop_back();
      it.board_done = 1'b1;
      position_items.push_back(it);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_feats.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d status %0d end %0d",
                                  out_data.feature_index, out_data.status, out_data.list_end));
      end else begin
        want_feat = expected_feats.pop_front();
        if (out_data.feature_index !== want_feat.feature_index) begin
          report_mismatch($sformatf("feature_index %0d, expected %0d",
                                    out_data.feature_index, want_feat.feature_index));
        end
        if (out_data.status !== want_feat.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want_feat.status));
        end
        if (out_data.list_end !== want_feat.list_end) begin
          report_mismatch($sformatf("list_end %0d, expected %0d (index %0d)",
                                    out_data.list_end, want_feat.list_end,
                                    want_feat.feature_index));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("nnue_halfka_feature_list_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    int cap_plan [NUM_PHASES];
    int phase_base;
    nhfl_out_t none;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    gaps_on = 1'b1;
    err_count = 0;
    item_count = 0;
    stall_cycles = 0;
    none = '0;
    shadow_cap = CAP_RESET;
    for (int i = 0; i < NUM_PLANES; i++) shadow_planes[i] = '0;
    cap_plan = '{0, 63, 2, $urandom_range(3, 30), 1, 32, $urandom_range(0, 63), 31};

    board_rows.push_back(mk_row(WHITE, KIND_SPARE_LO, '1, 1'b0, 1'b1, 1'b1));
    board_rows.push_back(mk_row(WHITE, KIND_PAWN, '1, 1'b1, 1'b1, 1'b1));
    board_rows.push_back(mk_row(WHITE, KIND_KING, 64'h1, 1'b1, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_KING, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_SPARE_HI, '1, 1'b1, 1'b0, 1'b0));
    board_rows.push_back(mk_row(WHITE, KIND_KING, 64'h1000_0000, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(WHITE, KIND_KING, 64'h200, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_KING, 64'h1000_0000_0000_0000, 1'b1, 1'b1, 1'b0));
    board_rows.push_back(mk_row(WHITE, KIND_KING, 64'h1, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_KING, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_PAWN, 64'h0100_0000_0000_0000, 1'b0, 1'b1, 1'b1));
    board_rows.push_back(mk_row(WHITE, KIND_KING, 64'h10, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_KING, 64'h1000_0000_0000_0000, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(WHITE, KIND_KNIGHT, 64'h10_0000, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_BISHOP, 64'h10_0000, 1'b1, 1'b1, 1'b1));
    board_rows.push_back(mk_row(WHITE, KIND_KING, 64'h11, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_KING, 64'h1000_0000_0000_0000, 1'b0, 1'b1, 1'b1));
    board_rows.push_back(mk_row(WHITE, KIND_KING, 64'h1, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_KING, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0));
    board_rows.push_back(mk_row(WHITE, KIND_QUEEN, 64'hFFFF_FFFE, 1'b0, 1'b1, 1'b1));
    board_rows.push_back(mk_row(WHITE, KIND_KING, 64'h1, 1'b1, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_KING, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0));
    board_rows.push_back(mk_row(BLACK, KIND_ROOK, 64'h7FFF_FFFE_0000_0000, 1'b1, 1'b1, 1'b0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (board_rows[r]) begin
      push_transaction(board_rows[r].item, board_rows[r].typed, board_rows[r].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained(DRAIN_CYCLES);
      write_capacity(CAP_W'(cap_plan[p]));
      gaps_on = (p != QUIET_PHASE);
      phase_base = item_count;
      while (item_count < phase_base + PHASE_ITEMS) begin
        build_position();
        foreach (position_items[i]) push_transaction(position_items[i], 1'b0, none);
      end
    end

    wait_drained(DRAIN_CYCLES);
    if (err_count == 0) begin
      $display("nnue_halfka_feature_list_top_test: done, clean");
    end else begin
      $display("nnue_halfka_feature_list_top_test: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/nhfl_pkg.sv
design/nhfl_front.sv
design/nhfl_queue.sv
design/nhfl_back.sv
design/nnue_halfka_feature_list_top.sv
tb/nnue_halfka_feature_list_top_test.sv
